FILE: rtl/ndr_pkg.sv
package ndr_pkg;

	// Internal side width: holds any 13-bit register value after clamping.
	localparam int SIDE_W = 13;
	// Product of two sides, the widest dividend the shared divider sees.
	localparam int NUM_W = 2 * SIDE_W;
	// Output position fields are 12 bits wide.
	localparam int POS_W = 12;
	localparam int PIX_W = 16;
	localparam int COMP_W = 8;
	localparam int CFG_IDX_W = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DIM = 2'd2;

	// Which of the four frame-start divisions is being set up or stored.
	typedef enum logic [1:0] {
		DIV_DST_W,
		DIV_DST_H,
		DIV_COL_STEP,
		DIV_ROW_STEP
	} div_sel_t;

	typedef enum logic [3:0] {
		ST_PROD_W,
		ST_GO_W,
		ST_WAIT_W,
		ST_PROD_H,
		ST_GO_H,
		ST_WAIT_H,
		ST_GO_C,
		ST_WAIT_C,
		ST_GO_R,
		ST_WAIT_R,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic     clear;
		logic     load_prod;
		logic     div_start;
		div_sel_t div_sel;
		logic     run;
	} ndr_cmd_t;

	typedef struct packed {
		logic restart;
		logic div_done;
	} ndr_status_t;

endpackage

FILE: rtl/ndr_div.sv
module ndr_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [ndr_pkg::NUM_W-1:0] dividend,
	input  logic [ndr_pkg::SIDE_W-1:0] divisor,
	output logic                      done,
	output logic [ndr_pkg::NUM_W-1:0] quotient,
	output logic [ndr_pkg::SIDE_W-1:0] remainder
);

	localparam int NW = ndr_pkg::NUM_W;
	localparam int SW = ndr_pkg::SIDE_W;
	localparam int CNT_W = $clog2(NW);

	logic [NW-1:0]    quo_q;
	logic [SW-1:0]    rem_q;
	logic [SW-1:0]    dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [SW:0] trial;
	logic [SW:0] diff;
	logic        ge;
	logic        last;

	// One quotient bit per cycle, restoring form.
	assign trial = {rem_q, quo_q[NW-1]};
	assign ge = trial >= {1'b0, dvs_q};
	assign diff = trial - {1'b0, dvs_q};
	assign last = cnt_q == CNT_W'(NW - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && last;
			if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], ge};
			rem_q <= ge ? diff[SW-1:0] : trial[SW-1:0];
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
	assign remainder = rem_q;

endmodule

FILE: rtl/ndr_ctrl.sv
module ndr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  ndr_pkg::ndr_status_t status,
	output ndr_pkg::ndr_cmd_t   cmd
);

	ndr_pkg::state_t state_q;
	ndr_pkg::state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ndr_pkg::ST_PROD_W;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ndr_pkg::ST_PROD_W: state_nx = ndr_pkg::ST_GO_W;
			ndr_pkg::ST_GO_W:   state_nx = ndr_pkg::ST_WAIT_W;
			ndr_pkg::ST_WAIT_W: if (status.div_done) begin
				state_nx = ndr_pkg::ST_PROD_H;
			end
			ndr_pkg::ST_PROD_H: state_nx = ndr_pkg::ST_GO_H;
			ndr_pkg::ST_GO_H:   state_nx = ndr_pkg::ST_WAIT_H;
			ndr_pkg::ST_WAIT_H: if (status.div_done) begin
				state_nx = ndr_pkg::ST_GO_C;
			end
			ndr_pkg::ST_GO_C:   state_nx = ndr_pkg::ST_WAIT_C;
			ndr_pkg::ST_WAIT_C: if (status.div_done) begin
				state_nx = ndr_pkg::ST_GO_R;
			end
			ndr_pkg::ST_GO_R:   state_nx = ndr_pkg::ST_WAIT_R;
			ndr_pkg::ST_WAIT_R: if (status.div_done) begin
				state_nx = ndr_pkg::ST_RUN;
			end
			ndr_pkg::ST_RUN:    state_nx = ndr_pkg::ST_RUN;
			default:            state_nx = ndr_pkg::ST_PROD_W;
		endcase
		// A register write restarts the size computation from any state.
		if (status.restart) begin
			state_nx = ndr_pkg::ST_PROD_W;
		end
	end

	always_comb begin
		cmd.clear = 1'b0;
		cmd.load_prod = 1'b0;
		cmd.div_start = 1'b0;
		cmd.div_sel = ndr_pkg::DIV_DST_W;
		cmd.run = 1'b0;
		unique case (state_q)
			ndr_pkg::ST_PROD_W: begin
				cmd.clear = 1'b1;
				cmd.load_prod = 1'b1;
			end
			ndr_pkg::ST_GO_W: cmd.div_start = 1'b1;
			ndr_pkg::ST_WAIT_W: cmd.div_sel = ndr_pkg::DIV_DST_W;
			ndr_pkg::ST_PROD_H: begin
				cmd.load_prod = 1'b1;
				cmd.div_sel = ndr_pkg::DIV_DST_H;
			end
			ndr_pkg::ST_GO_H: begin
				cmd.div_start = 1'b1;
				cmd.div_sel = ndr_pkg::DIV_DST_H;
			end
			ndr_pkg::ST_WAIT_H: cmd.div_sel = ndr_pkg::DIV_DST_H;
			ndr_pkg::ST_GO_C: begin
				cmd.div_start = 1'b1;
				cmd.div_sel = ndr_pkg::DIV_COL_STEP;
			end
			ndr_pkg::ST_WAIT_C: cmd.div_sel = ndr_pkg::DIV_COL_STEP;
			ndr_pkg::ST_GO_R: begin
				cmd.div_start = 1'b1;
				cmd.div_sel = ndr_pkg::DIV_ROW_STEP;
			end
			ndr_pkg::ST_WAIT_R: cmd.div_sel = ndr_pkg::DIV_ROW_STEP;
			ndr_pkg::ST_RUN: cmd.run = 1'b1;
			default: cmd.clear = 1'b0;
		endcase
	end

endmodule

FILE: rtl/ndr_dp.sv
module ndr_dp #(
	parameter int MAX_SIDE = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ndr_pkg::ndr_cmd_t              cmd,
	output ndr_pkg::ndr_status_t           status,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ndr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ndr_pkg::SIDE_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [ndr_pkg::COMP_W-1:0]     red,
	input  logic [ndr_pkg::COMP_W-1:0]     green,
	input  logic [ndr_pkg::COMP_W-1:0]     blue,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [ndr_pkg::PIX_W-1:0]      pixel565,
	output logic [ndr_pkg::POS_W-1:0]      out_col,
	output logic [ndr_pkg::POS_W-1:0]      out_row,
	output logic                           end_of_row,
	output logic                           end_of_frame,
	output logic [ndr_pkg::SIDE_W-1:0]     out_width,
	output logic [ndr_pkg::SIDE_W-1:0]     out_height
);

	localparam int SW = ndr_pkg::SIDE_W;
	localparam int NW = ndr_pkg::NUM_W;
	localparam int PW = ndr_pkg::POS_W;

	function automatic logic [SW-1:0] clamp_side(input logic [SW-1:0] v, input logic floor_one);
		logic [SW-1:0] r;
		begin
			r = v;
			if (floor_one && v == '0) begin
				r = SW'(1);
			end else if (32'(v) > 32'(MAX_SIDE)) begin
				r = SW'(MAX_SIDE);
			end
			return r;
		end
	endfunction

	// Configuration registers.
	logic [SW-1:0] src_w_q;
	logic [SW-1:0] src_h_q;
	logic [SW-1:0] max_q;
	logic          cfg_hit;

	always_comb begin
		unique case (cfg_index)
			ndr_pkg::REG_SRC_WIDTH:  cfg_hit = 1'b1;
			ndr_pkg::REG_SRC_HEIGHT: cfg_hit = 1'b1;
			ndr_pkg::REG_MAX_DIM:    cfg_hit = 1'b1;
			default:                 cfg_hit = 1'b0;
		endcase
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= SW'(1);
			src_h_q <= SW'(1);
			max_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ndr_pkg::REG_SRC_WIDTH:  src_w_q <= cfg_data;
				ndr_pkg::REG_SRC_HEIGHT: src_h_q <= cfg_data;
				ndr_pkg::REG_MAX_DIM:    max_q <= cfg_data;
				default:                 max_q <= max_q;
			endcase
		end
	end

	assign status.restart = cfg_valid && cfg_ready && cfg_hit;

	// Effective sides.
	logic [SW-1:0] w;
	logic [SW-1:0] h;
	logic [SW-1:0] m;
	logic [SW-1:0] longer;
	logic          scale;

	assign w = clamp_side(src_w_q, 1'b1);
	assign h = clamp_side(src_h_q, 1'b1);
	assign m = clamp_side(max_q, 1'b0);
	assign longer = (w > h) ? w : h;
	assign scale = (m != '0) && (longer > m);

	// Frame-start arithmetic: one product register and the shared divider.
	logic [NW-1:0]      prod_q;
	logic [NW-1:0]      div_num;
	logic [SW-1:0]      div_den;
	logic               div_done;
	logic [NW-1:0]      div_quo;
	logic [SW-1:0]      div_rem;
	ndr_pkg::div_sel_t  sel_q;
	logic [SW-1:0]      dw_q;
	logic [SW-1:0]      dh_q;
	logic [SW-1:0]      cq_q;
	logic [SW-1:0]      cr_q;
	logic [SW-1:0]      rq_q;
	logic [SW-1:0]      rr_q;
	logic [SW-1:0]      scaled_side;

	always_ff @(posedge clk) begin
		if (cmd.load_prod) begin
			prod_q <= NW'((cmd.div_sel == ndr_pkg::DIV_DST_H) ? h : w) * NW'(m);
		end
	end

	always_comb begin
		case (cmd.div_sel) inside
			ndr_pkg::DIV_DST_W, ndr_pkg::DIV_DST_H: begin
				div_num = prod_q;
				div_den = longer;
			end
			ndr_pkg::DIV_COL_STEP: begin
				div_num = NW'(w);
				div_den = dw_q;
			end
			default: begin
				div_num = NW'(h);
				div_den = dh_q;
			end
		endcase
	end

	ndr_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_num),
		.divisor   (div_den),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign status.div_done = div_done;
	assign scaled_side = (div_quo[SW-1:0] == '0) ? SW'(1) : div_quo[SW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			sel_q <= cmd.div_sel;
		end
		if (div_done) begin
			case (sel_q)
				ndr_pkg::DIV_DST_W: dw_q <= scale ? scaled_side : w;
				ndr_pkg::DIV_DST_H: dh_q <= scale ? scaled_side : h;
				ndr_pkg::DIV_COL_STEP: begin
					cq_q <= div_quo[SW-1:0];
					cr_q <= div_rem;
				end
				default: begin
					rq_q <= div_quo[SW-1:0];
					rr_q <= div_rem;
				end
			endcase
		end
	end

	// Position counters and incremental nearest-neighbour picks.
	logic [SW-1:0] src_col_q;
	logic [SW-1:0] src_row_q;
	logic [SW-1:0] dst_col_q;
	logic [SW-1:0] dst_row_q;
	logic [SW-1:0] pick_col_q;
	logic [SW-1:0] pick_row_q;
	logic [SW-1:0] col_err_q;
	logic [SW-1:0] row_err_q;

	logic          out_valid_q;
	logic          accept;
	logic          hit;
	logic          row_end;
	logic          frame_end;
	logic [SW:0]   col_sum;
	logic          col_carry;
	logic [SW:0]   col_left;
	logic [SW:0]   row_sum;
	logic          row_carry;
	logic [SW:0]   row_left;
	logic [SW-1:0] pick_col_nx;
	logic [SW-1:0] pick_row_nx;

	assign in_stall = !cmd.run || (out_valid_q && out_stall);
	assign accept = in_valid && !in_stall;

	assign hit = (src_row_q == pick_row_q) && (src_col_q == pick_col_q);
	assign row_end = ({1'b0, src_col_q} + (SW + 1)'(1)) >= {1'b0, w};
	assign frame_end = ({1'b0, src_row_q} + (SW + 1)'(1)) >= {1'b0, h};

	assign col_sum = {1'b0, col_err_q} + {1'b0, cr_q};
	assign col_carry = col_sum >= {1'b0, dw_q};
	assign col_left = col_sum - {1'b0, dw_q};
	assign pick_col_nx = pick_col_q + cq_q + {{(SW - 1){1'b0}}, col_carry};

	assign row_sum = {1'b0, row_err_q} + {1'b0, rr_q};
	assign row_carry = row_sum >= {1'b0, dh_q};
	assign row_left = row_sum - {1'b0, dh_q};
	assign pick_row_nx = pick_row_q + rq_q + {{(SW - 1){1'b0}}, row_carry};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q <= '0;
			src_row_q <= '0;
			dst_col_q <= '0;
			dst_row_q <= '0;
			pick_col_q <= '0;
			pick_row_q <= '0;
			col_err_q <= '0;
			row_err_q <= '0;
		end else if (cmd.clear) begin
			src_col_q <= '0;
			src_row_q <= '0;
			dst_col_q <= '0;
			dst_row_q <= '0;
			pick_col_q <= '0;
			pick_row_q <= '0;
			col_err_q <= '0;
			row_err_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				src_col_q <= '0;
				dst_col_q <= '0;
				pick_col_q <= '0;
				col_err_q <= '0;
				if (frame_end) begin
					src_row_q <= '0;
					dst_row_q <= '0;
					pick_row_q <= '0;
					row_err_q <= '0;
				end else begin
					src_row_q <= src_row_q + SW'(1);
					if (src_row_q == pick_row_q) begin
						dst_row_q <= dst_row_q + SW'(1);
						pick_row_q <= pick_row_nx;
						row_err_q <= row_carry ? row_left[SW-1:0] : row_sum[SW-1:0];
					end
				end
			end else begin
				src_col_q <= src_col_q + SW'(1);
				if (hit) begin
					dst_col_q <= dst_col_q + SW'(1);
					pick_col_q <= pick_col_nx;
					col_err_q <= col_carry ? col_left[SW-1:0] : col_sum[SW-1:0];
				end
			end
		end
	end

	// Output register.
	logic [ndr_pkg::PIX_W-1:0] pixel_q;
	logic [PW-1:0]             out_col_q;
	logic [PW-1:0]             out_row_q;
	logic                      eor_q;
	logic                      eof_q;
	logic                      eor;

	assign eor = (dst_col_q + SW'(1)) == dw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && hit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && hit) begin
			pixel_q <= {red[7:3], green[7:2], blue[7:3]};
			out_col_q <= dst_col_q[PW-1:0];
			out_row_q <= dst_row_q[PW-1:0];
			eor_q <= eor;
			eof_q <= eor && ((dst_row_q + SW'(1)) == dh_q);
		end
	end

	assign out_valid = out_valid_q;
	assign pixel565 = pixel_q;
	assign out_col = out_col_q;
	assign out_row = out_row_q;
	assign end_of_row = eor_q;
	assign end_of_frame = eof_q;
	assign out_width = dw_q;
	assign out_height = dh_q;

endmodule

FILE: rtl/nearest_downscale_rgb565_top.sv
// Channel   Direction  Handshake            Payload
// cfg       in         cfg_valid/cfg_ready  cfg_index, cfg_data
// in        in         in_valid/in_stall    red, green, blue
// out       out        out_valid/out_stall  pixel565, out_col, out_row, end_of_row,
//                                           end_of_frame, out_width, out_height
//
// After reset and after every write to a known register, the block computes the
// output size and the pick steps with four 26-step divisions on one shared divider,
// and in_stall stays high meanwhile.
// Once running, one source pixel is taken per cycle while in_stall is low; each
// transfer yields zero or one output pixel, registered in a single output register.
// While running, in_stall rises only when that register is full and out_stall holds it.
// Reset is asynchronous and active low on arst_n.
module nearest_downscale_rgb565_top #(
	parameter int MAX_SIDE = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ndr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ndr_pkg::SIDE_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [ndr_pkg::COMP_W-1:0]    red,
	input  logic [ndr_pkg::COMP_W-1:0]    green,
	input  logic [ndr_pkg::COMP_W-1:0]    blue,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ndr_pkg::PIX_W-1:0]     pixel565,
	output logic [ndr_pkg::POS_W-1:0]     out_col,
	output logic [ndr_pkg::POS_W-1:0]     out_row,
	output logic                          end_of_row,
	output logic                          end_of_frame,
	output logic [ndr_pkg::SIDE_W-1:0]    out_width,
	output logic [ndr_pkg::SIDE_W-1:0]    out_height
);

	// The controller sequences the frame-start arithmetic and then enables the
	// pixel path; the datapath owns the configuration registers, the divider and the counters.
	ndr_pkg::ndr_cmd_t    cmd;
	ndr_pkg::ndr_status_t status;

	ndr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	// Column and row picks advance by a precomputed quotient and remainder per
	// output pixel, so no division is needed while pixels stream through.
	ndr_dp #(
		.MAX_SIDE (MAX_SIDE)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel565     (pixel565),
		.out_col      (out_col),
		.out_row      (out_row),
		.end_of_row   (end_of_row),
		.end_of_frame (end_of_frame),
		.out_width    (out_width),
		.out_height   (out_height)
	);

endmodule

FILE: tb/tb_nearest_downscale_rgb565_top.sv
`timescale 1ns / 1ps

module tb_nearest_downscale_rgb565_top;

	localparam int CFG_IDX_W = ndr_pkg::CFG_IDX_W;
	localparam int COMP_W = ndr_pkg::COMP_W;
	localparam int PIX_W = ndr_pkg::PIX_W;
	localparam int POS_W = ndr_pkg::POS_W;
	localparam int SIDE_W = ndr_pkg::SIDE_W;

	localparam int SIDE_LIMIT = 4096;
	// Index 3 is not mapped to any register; writes to it must be dropped.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int MAX_GAP = 8;
	// Cycles to let the output register drain after the last expected pixel.
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES = 20;
	localparam int LONG_HOLD = 80;
	localparam int HOLD_MARKS [2] = '{25, 150};
	// Longest quiet stretch: the size computation, a long hold, and slack.
	localparam int QUIET_LIMIT = 2000;
	localparam int RANDOM_PIXELS = 480;

	typedef struct {
		logic [COMP_W-1:0] r;
		logic [COMP_W-1:0] g;
		logic [COMP_W-1:0] b;
	} rgb_t;

	typedef struct {
		logic [PIX_W-1:0]  pix;
		logic [POS_W-1:0]  col;
		logic [POS_W-1:0]  row;
		logic              eor;
		logic              eof;
		logic [SIDE_W-1:0] w;
		logic [SIDE_W-1:0] h;
	} pix_out_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [SIDE_W-1:0]    cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [COMP_W-1:0]    red = '0;
	logic [COMP_W-1:0]    green = '0;
	logic [COMP_W-1:0]    blue = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [PIX_W-1:0]     pixel565;
	logic [POS_W-1:0]     out_col;
	logic [POS_W-1:0]     out_row;
	logic                 end_of_row;
	logic                 end_of_frame;
	logic [SIDE_W-1:0]    out_width;
	logic [SIDE_W-1:0]    out_height;

	nearest_downscale_rgb565_top #(
		.MAX_SIDE(SIDE_LIMIT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.red(red),
		.green(green),
		.blue(blue),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel565(pixel565),
		.out_col(out_col),
		.out_row(out_row),
		.end_of_row(end_of_row),
		.end_of_frame(end_of_frame),
		.out_width(out_width),
		.out_height(out_height)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Source pixels waiting for the driver, and output pixels still owed by the block.
	rgb_t     src_pixels[$];
	pix_out_t expected_pixels[$];

	// Shared control between the stimulus sequence and the clocked processes.
	bit idle_on = 1'b0;
	int mismatches = 0;
	int pixels_checked = 0;

	// Handshake history: whether the last rising edge completed a transfer.
	logic in_fire = 1'b0;
	logic out_fire = 1'b0;

	// Scaler state as the block should hold it.
	logic [SIDE_W-1:0] reg_src_w;
	logic [SIDE_W-1:0] reg_src_h;
	logic [SIDE_W-1:0] reg_max_dim;
	int unsigned frame_w, frame_h;
	int unsigned src_col, src_row;
	int unsigned next_out_col, next_out_row;
	int unsigned pick_col, pick_row;

	function automatic int unsigned limit_side(int unsigned v, int unsigned lo);
		if (v < lo) return lo;
		if (v > SIDE_LIMIT) return SIDE_LIMIT;
		return v;
	endfunction

	// Recomputes the output size from the registers and rewinds every counter to the
	// top left corner. Any accepted write to a mapped register lands here.
	task automatic restart_frame();
		int unsigned w, h, m, longer;
		w = limit_side(32'(reg_src_w), 1);
		h = limit_side(32'(reg_src_h), 1);
		m = limit_side(32'(reg_max_dim), 0);
		longer = (w > h) ? w : h;
		frame_w = w;
		frame_h = h;
		if (m > 0 && longer > m) begin
			frame_w = w * m / longer;
			frame_h = h * m / longer;
			if (frame_w < 1) frame_w = 1;
			if (frame_h < 1) frame_h = 1;
		end
		src_col = 0;
		src_row = 0;
		next_out_col = 0;
		next_out_row = 0;
		pick_col = 0;
		pick_row = 0;
	endtask

	// Advances the scaler by one source pixel. When the source position is the
	// nearest-neighbor pick for the next output pixel, that pixel is queued.
	task automatic scale_pixel(logic [COMP_W-1:0] r, logic [COMP_W-1:0] g,
			logic [COMP_W-1:0] b);
		int unsigned w, h;
		pix_out_t e;
		bit on_pick_row;
		w = limit_side(32'(reg_src_w), 1);
		h = limit_side(32'(reg_src_h), 1);
		if (src_row == pick_row && src_col == pick_col) begin
			e.pix = {r[7:3], g[7:2], b[7:3]};
			e.col = POS_W'(next_out_col);
			e.row = POS_W'(next_out_row);
			e.eor = (next_out_col + 1 == frame_w);
			e.eof = e.eor && (next_out_row + 1 == frame_h);
			e.w = SIDE_W'(frame_w);
			e.h = SIDE_W'(frame_h);
			expected_pixels.push_back(e);
			next_out_col++;
			// Past the last output column this lands on w and is never reached.
			pick_col = next_out_col * w / frame_w;
		end
		if (src_col + 1 >= w) begin
			on_pick_row = (src_row == pick_row);
			src_col = 0;
			next_out_col = 0;
			pick_col = 0;
			if (src_row + 1 >= h) begin
				// Bottom right corner: the next pixel opens a new frame.
				src_row = 0;
				next_out_row = 0;
				pick_row = 0;
			end else begin
				src_row++;
				if (on_pick_row) begin
					next_out_row++;
					pick_row = next_out_row * h / frame_h;
				end
			end
		end else begin
			src_col++;
		end
	endtask

	task automatic report_mismatch(string msg);
		mismatches++;
		$display("%0t: output transfer %0d: %s", $time, pixels_checked, msg);
	endtask

	task automatic check_field(string name, logic [PIX_W-1:0] got, logic [PIX_W-1:0] want);
		if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	// Input side: every accepted source pixel goes through the scaler model at the
	// same edge the block takes it.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_fire <= 1'b0;
		end else begin
			in_fire <= in_valid && !in_stall;
			if (in_valid && !in_stall) scale_pixel(red, green, blue);
		end
	end

	// Driver. A transfer retires the current pixel; a random gap bounded by MAX_GAP is
	// drawn before the next one when idling is on. The payload only moves at the
	// falling edge and never while a pixel is offered but not yet taken.
	logic next_valid;
	int   gap_left = 0;
	rgb_t item;

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
		end else begin
			next_valid = in_valid;
			if (in_valid && in_fire) begin
				next_valid = 1'b0;
				gap_left = idle_on ? $urandom_range(0, MAX_GAP) : 0;
			end
			if (!next_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (src_pixels.size() != 0) begin
					item = src_pixels.pop_front();
					red <= item.r;
					green <= item.g;
					blue <= item.b;
					next_valid = 1'b1;
				end
			end
			in_valid <= next_valid;
		end
	end

	// Monitor: each output transfer is matched against the oldest owed pixel.
	pix_out_t want;

	always @(posedge clk) begin
		if (!arst_n) begin
			out_fire <= 1'b0;
		end else begin
			out_fire <= out_valid && !out_stall;
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					report_mismatch($sformatf("pixel565 %0h arrived with nothing expected",
						pixel565));
				end else begin
					want = expected_pixels.pop_front();
					check_field("pixel565", pixel565, want.pix);
					check_field("out_col", PIX_W'(out_col), PIX_W'(want.col));
					check_field("out_row", PIX_W'(out_row), PIX_W'(want.row));
					check_field("end_of_row", PIX_W'(end_of_row), PIX_W'(want.eor));
					check_field("end_of_frame", PIX_W'(end_of_frame), PIX_W'(want.eof));
					check_field("out_width", PIX_W'(out_width), PIX_W'(want.w));
					check_field("out_height", PIX_W'(out_height), PIX_W'(want.h));
				end
				pixels_checked++;
			end
		end
	end

	// Receiver. After each transfer it stalls for a drawn number of cycles. Twice in
	// the run, while the sender is offering, it holds off for a long stretch so the
	// output register fills and the block has to stall its input.
	int stall_left = 0;
	int hold_left = 0;
	int holds_done = 0;

	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
			hold_left = 0;
		end else begin
			if (holds_done < 2 && pixels_checked >= HOLD_MARKS[holds_done] && in_valid) begin
				hold_left = LONG_HOLD;
				holds_done++;
			end
			if (out_fire) stall_left = idle_on ? $urandom_range(0, MAX_GAP) : 0;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: ends the run if no channel moves a transfer for too long.
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
			$display("FAIL");
			$finish;
		end
	end

	// Register write on the configuration channel. The model takes the write at the
	// edge where it is accepted; an unmapped index leaves the frame running.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIDE_W-1:0] value);
		bit known;
		known = 1'b1;
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			ndr_pkg::REG_SRC_WIDTH: reg_src_w = value;
			ndr_pkg::REG_SRC_HEIGHT: reg_src_h = value;
			ndr_pkg::REG_MAX_DIM: reg_max_dim = value;
			default: known = 1'b0;
		endcase
		if (known) restart_frame();
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_rgb(logic [COMP_W-1:0] r, logic [COMP_W-1:0] g, logic [COMP_W-1:0] b);
		rgb_t p;
		p.r = r;
		p.g = g;
		p.b = b;
		src_pixels.push_back(p);
	endtask

	task automatic queue_pixels(int n);
		for (int i = 0; i < n; i++)
			queue_rgb(COMP_W'($urandom), COMP_W'($urandom), COMP_W'($urandom));
	endtask

	// Waits until every queued pixel has been taken and every owed output has come
	// back, then lets the output settle in case the last pixels produced nothing.
	task automatic wait_idle();
		while (src_pixels.size() != 0 || in_valid || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly small sides so frames wrap often; now and then zero or a large value.
	function automatic logic [SIDE_W-1:0] random_side();
		case ($urandom_range(0, 9))
			0: return SIDE_W'($urandom_range(0, 1));
			1: return SIDE_W'($urandom_range(13, 8191));
			default: return SIDE_W'($urandom_range(1, 12));
		endcase
	endfunction

	function automatic logic [SIDE_W-1:0] random_limit();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return SIDE_W'($urandom);
			default: return SIDE_W'($urandom_range(1, 12));
		endcase
	endfunction

	// Fixed corner settings: oversized sides, the full 4096 side, max_dim of one and
	// above the limit. Frames this large are only fed in part.
	localparam int N_CORNERS = 5;
	localparam logic [SIDE_W-1:0] CORNER_W [N_CORNERS] = '{8191, 4096, 1, 8191, 8191};
	localparam logic [SIDE_W-1:0] CORNER_H [N_CORNERS] = '{8191, 8191, 4096, 8191, 8191};
	localparam logic [SIDE_W-1:0] CORNER_M [N_CORNERS] = '{3, 0, 4096, 1, 5000};
	localparam int CORNER_N [N_CORNERS] = '{64, 64, 20, 40, 10};

	logic [CFG_IDX_W-1:0] reg_order [3] = '{ndr_pkg::REG_SRC_WIDTH, ndr_pkg::REG_SRC_HEIGHT,
		ndr_pkg::REG_MAX_DIM};

	initial begin
		int random_pixels;
		int phase_no;
		int first;
		int n;
		logic [CFG_IDX_W-1:0] idx;

		random_pixels = 0;
		phase_no = 0;
		reg_src_w = SIDE_W'(1);
		reg_src_h = SIDE_W'(1);
		reg_max_dim = '0;
		restart_frame();

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset size is 1 x 1, so every pixel comes out as a full frame. Component
		// extremes, and low bits that the packing must drop.
		idle_on = 1'b0;
		queue_rgb(8'h00, 8'h00, 8'h00);
		queue_rgb(8'hFF, 8'hFF, 8'hFF);
		queue_rgb(8'h07, 8'h03, 8'h07);
		queue_rgb(8'hF8, 8'hFC, 8'hF8);
		wait_idle();

		// A write to the unmapped index in the middle of a 3 x 2 frame must not
		// restart it.
		write_reg(ndr_pkg::REG_SRC_WIDTH, 13'd3);
		write_reg(ndr_pkg::REG_SRC_HEIGHT, 13'd2);
		write_reg(ndr_pkg::REG_MAX_DIM, 13'd0);
		queue_pixels(2);
		wait_idle();
		write_reg(REG_UNUSED, 13'h1FFF);
		queue_pixels(4);
		wait_idle();

		// A zero width counts as one.
		write_reg(ndr_pkg::REG_SRC_WIDTH, 13'd0);
		queue_pixels(2);
		wait_idle();

		// 4 x 2 squeezed to 3 x 1: the row pick after the first row is never reached.
		write_reg(ndr_pkg::REG_SRC_WIDTH, 13'd4);
		write_reg(ndr_pkg::REG_MAX_DIM, 13'd3);
		queue_pixels(8);
		wait_idle();

		idle_on = 1'b1;
		for (int c = 0; c < N_CORNERS; c++) begin
			write_reg(ndr_pkg::REG_SRC_WIDTH, CORNER_W[c]);
			write_reg(ndr_pkg::REG_SRC_HEIGHT, CORNER_H[c]);
			write_reg(ndr_pkg::REG_MAX_DIM, CORNER_M[c]);
			queue_pixels(CORNER_N[c]);
			wait_idle();
		end

		// Random phases. Most rewrite all three registers in a random order; some keep
		// the frame running across the pause. Every sixth phase the sender stops
		// halfway until all owed pixels are back.
		while (random_pixels < RANDOM_PIXELS) begin
			idle_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 4) != 0) begin
				first = $urandom_range(0, 2);
				for (int k = 0; k < 3; k++) begin
					idx = reg_order[(first + k) % 3];
					write_reg(idx, (idx == ndr_pkg::REG_MAX_DIM) ? random_limit() : random_side());
				end
				if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, SIDE_W'($urandom));
			end
			n = $urandom_range(4, 60);
			if (phase_no % 6 == 0) begin
				queue_pixels(n / 2);
				wait_idle();
				queue_pixels(n - n / 2);
			end else begin
				queue_pixels(n);
			end
			wait_idle();
			random_pixels += n;
			phase_no++;
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
